### src/yuvpsnr_pkg.sv
// ----------------------------------------------------------------------------
// yuvpsnr_pkg
// Shared widths, codes and constants of the YUV 4:2:0 PSNR meter.
// ----------------------------------------------------------------------------
package yuvpsnr_pkg;

  localparam int DEF_MAX_DIM     = 4096;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int SAMPLE_W  = 8;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PLANE_W   = 2;
  localparam int PSNR_W    = 16;
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 16;
  localparam int PEAK_W    = 16;
  localparam int TEN_W     = 18;
  localparam int ROUND_SH  = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd352;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd288;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  localparam logic [PEAK_W-1:0] PEAK_SQ         = 16'd65025;
  localparam logic [TEN_W-1:0]  TEN_LOG10_2_Q16 = 18'd197283;
  localparam logic [PSNR_W-1:0] PSNR_MAX        = 16'hFFFF;

  // even-clamped largest side for a given dimension limit
  function automatic int dim_hi(input int max_dim);
    return max_dim - (max_dim % 2);
  endfunction

  // sample count width: holds the largest luma plane size
  function automatic int cnt_width(input int max_dim);
    return $clog2(dim_hi(max_dim) * dim_hi(max_dim) + 1);
  endfunction

  // squared error sum width
  function automatic int sse_width(input int max_dim);
    return cnt_width(max_dim) + SQ_W;
  endfunction

  // normalising word width of the logarithm unit
  function automatic int norm_width(input int in_w);
    return (in_w > MANT_W) ? in_w : MANT_W;
  endfunction

  // logarithm result width, integer part plus fraction
  function automatic int log_res_width(input int in_w);
    return $clog2(norm_width(in_w)) + FRAC_W;
  endfunction

endpackage

### src/yuvpsnr_queue.sv
// ----------------------------------------------------------------------------
// yuvpsnr_queue
// Small register FIFO carrying finished plane totals to the back end.
// ----------------------------------------------------------------------------
module yuvpsnr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### src/yuvpsnr_front.sv
// ----------------------------------------------------------------------------
// yuvpsnr_front
// Frame geometry registers and per-plane squared error accumulation.
// ----------------------------------------------------------------------------
module yuvpsnr_front #(
  parameter int MAX_DIM = yuvpsnr_pkg::DEF_MAX_DIM
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [yuvpsnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yuvpsnr_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [2*yuvpsnr_pkg::SAMPLE_W-1:0]    in_tdata,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [yuvpsnr_pkg::PLANE_W + yuvpsnr_pkg::cnt_width(MAX_DIM)
                + yuvpsnr_pkg::sse_width(MAX_DIM) - 1:0] q_data
);

  localparam int CFG_W  = yuvpsnr_pkg::CFG_W;
  localparam int SMP_W  = yuvpsnr_pkg::SAMPLE_W;
  localparam int DIM_HI = yuvpsnr_pkg::dim_hi(MAX_DIM);
  localparam int DIM_W  = $clog2(DIM_HI + 1);
  localparam int CNT_W  = yuvpsnr_pkg::cnt_width(MAX_DIM);
  localparam int SSE_W  = yuvpsnr_pkg::sse_width(MAX_DIM);

  logic [CFG_W-1:0]               frame_width_r, frame_height_r;
  logic [SSE_W-1:0]               sse_r, sse_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [yuvpsnr_pkg::PLANE_W-1:0] plane_r, plane_nxt;

  logic [SMP_W-1:0]        smp_ref, smp_test, diff;
  logic [2*SMP_W-1:0]      sq;
  logic [DIM_W-1:0]        w_cl, h_cl, side_a, side_b;
  logic [2*DIM_W-1:0]      size_full;
  logic [CNT_W-1:0]        size;
  logic                    accept, plane_end;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W:0] ve;
    ve = {1'b0, v[CFG_W-1:1], 1'b0};
    if (ve < (CFG_W + 1)'(2)) ve = (CFG_W + 1)'(2);
    if (ve > (CFG_W + 1)'(DIM_HI)) ve = (CFG_W + 1)'(DIM_HI);
    return ve[DIM_W-1:0];
  endfunction

  assign smp_ref  = in_tdata[SMP_W-1:0];
  assign smp_test = in_tdata[2*SMP_W-1:SMP_W];
  assign diff     = (smp_ref >= smp_test) ? smp_ref - smp_test : smp_test - smp_ref;
  assign sq       = diff * diff;

  assign w_cl      = clamp_dim(frame_width_r);
  assign h_cl      = clamp_dim(frame_height_r);
  assign side_a    = (plane_r == yuvpsnr_pkg::PLANE_Y) ? w_cl : w_cl >> 1;
  assign side_b    = (plane_r == yuvpsnr_pkg::PLANE_Y) ? h_cl : h_cl >> 1;
  assign size_full = side_a * side_b;
  assign size      = size_full[CNT_W-1:0];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign count_nxt = count_r + CNT_W'(1);
  assign sse_nxt   = sse_r + SSE_W'(sq);
  assign plane_end = (count_nxt >= size);
  assign plane_nxt = (plane_r == yuvpsnr_pkg::PLANE_V) ? yuvpsnr_pkg::PLANE_Y
                                                       : plane_r + 2'd1;

  assign q_push = accept && plane_end;
  assign q_data = {plane_r, count_nxt, sse_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= yuvpsnr_pkg::RST_FRAME_WIDTH;
      frame_height_r <= yuvpsnr_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yuvpsnr_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        yuvpsnr_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sse_r   <= '0;
      count_r <= '0;
      plane_r <= yuvpsnr_pkg::PLANE_Y;
    end else if (accept) begin
      if (plane_end) begin
        sse_r   <= '0;
        count_r <= '0;
        plane_r <= plane_nxt;
      end else begin
        sse_r   <= sse_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

### src/yuvpsnr_log2.sv
// ----------------------------------------------------------------------------
// yuvpsnr_log2
// Iterative base-2 logarithm in Q.16: normalise, then sixteen squarings.
// ----------------------------------------------------------------------------
module yuvpsnr_log2 #(
  parameter int IN_W = 40
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [IN_W-1:0]                              x,
  output logic                                         done,
  output logic [yuvpsnr_pkg::log_res_width(IN_W)-1:0]  result
);

  localparam int MANT_W = yuvpsnr_pkg::MANT_W;
  localparam int FRAC_W = yuvpsnr_pkg::FRAC_W;
  localparam int NW     = yuvpsnr_pkg::norm_width(IN_W);
  localparam int E_W    = $clog2(NW);
  localparam int K_W    = $clog2(FRAC_W);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR, L_DONE} lstate_t;

  lstate_t             state_r;
  logic [NW-1:0]       norm_r;
  logic [E_W-1:0]      e_r;
  logic [MANT_W-1:0]   m_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [K_W-1:0]      k_r;
  logic [2*MANT_W-1:0] prod;
  logic [MANT_W:0]     sq;

  assign prod   = m_r * m_r;
  assign sq     = prod[2*MANT_W-1 -: MANT_W+1];
  assign done   = (state_r == L_DONE);
  assign result = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            norm_r  <= NW'(x);
            e_r     <= E_W'(NW - 1);
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (norm_r[NW-1]) begin
            m_r     <= norm_r[NW-1 -: MANT_W];
            frac_r  <= '0;
            k_r     <= '0;
            state_r <= L_SQR;
          end else if (norm_r[NW-1 -: 4] == 4'd0) begin
            norm_r <= norm_r << 4;
            e_r    <= e_r - E_W'(4);
          end else begin
            norm_r <= norm_r << 1;
            e_r    <= e_r - E_W'(1);
          end
        end
        L_SQR: begin
          m_r    <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
          frac_r <= {frac_r[FRAC_W-2:0], sq[MANT_W]};
          k_r    <= k_r + K_W'(1);
          if (k_r == K_W'(FRAC_W - 1)) begin
            state_r <= L_DONE;
          end
        end
        L_DONE: state_r <= L_IDLE;
        default: state_r <= L_IDLE;
      endcase
    end
  end

endmodule

### src/yuvpsnr_back.sv
// ----------------------------------------------------------------------------
// yuvpsnr_back
// Turns a plane total into PSNR in Q8.8 dB and holds it for the output.
// ----------------------------------------------------------------------------
module yuvpsnr_back #(
  parameter int MAX_DIM = yuvpsnr_pkg::DEF_MAX_DIM
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [yuvpsnr_pkg::PLANE_W + yuvpsnr_pkg::cnt_width(MAX_DIM)
                + yuvpsnr_pkg::sse_width(MAX_DIM) - 1:0] q_data,
  output logic                                   log_start,
  output logic [yuvpsnr_pkg::sse_width(MAX_DIM)-1:0] log_x,
  input  logic                                   log_done,
  input  logic [yuvpsnr_pkg::log_res_width(yuvpsnr_pkg::sse_width(MAX_DIM))-1:0]
                                                 log_result,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [yuvpsnr_pkg::PSNR_W-1:0]         out_tdata,
  output logic [yuvpsnr_pkg::PLANE_W:0]          out_tuser,
  output logic                                   out_tlast
);

  localparam int PLANE_W = yuvpsnr_pkg::PLANE_W;
  localparam int PSNR_W  = yuvpsnr_pkg::PSNR_W;
  localparam int CNT_W   = yuvpsnr_pkg::cnt_width(MAX_DIM);
  localparam int SSE_W   = yuvpsnr_pkg::sse_width(MAX_DIM);
  localparam int RES_W   = yuvpsnr_pkg::log_res_width(SSE_W);
  localparam int PW      = RES_W + yuvpsnr_pkg::TEN_W;
  localparam int SH      = yuvpsnr_pkg::ROUND_SH;
  localparam int SH_W    = PW + 1 - SH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LOGN, S_WAITN, S_LOGD, S_WAITD, S_SCALE, S_ROUND, S_OUT
  } bstate_t;

  bstate_t            state_r;
  logic [PLANE_W-1:0] plane_r;
  logic [CNT_W-1:0]   count_r;
  logic [SSE_W-1:0]   sse_r, num_r;
  logic               zero_r;
  logic [RES_W-1:0]   lnum_r, diff_r;
  logic [PW-1:0]      prod_r;
  logic [PSNR_W-1:0]  psnr_r;

  logic               out_valid_r, out_exact_r, out_last_r;
  logic [PLANE_W-1:0] out_plane_r;
  logic [PSNR_W-1:0]  out_psnr_r;

  logic [PW:0]        rnd;
  logic [SH_W-1:0]    rnd_sh;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign log_start = ((state_r == S_LOGN) && !zero_r) || (state_r == S_LOGD);
  assign log_x     = (state_r == S_LOGD) ? sse_r : num_r;

  assign rnd    = {1'b0, prod_r} + ((PW + 1)'(1) << (SH - 1));
  assign rnd_sh = rnd[PW:SH];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_psnr_r;
  assign out_tuser  = {out_exact_r, out_plane_r};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            {plane_r, count_r, sse_r} <= q_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          num_r   <= count_r * yuvpsnr_pkg::PEAK_SQ;
          zero_r  <= (sse_r == '0);
          state_r <= S_LOGN;
        end
        S_LOGN: begin
          if (zero_r) begin
            psnr_r  <= yuvpsnr_pkg::PSNR_MAX;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WAITN;
          end
        end
        S_WAITN: begin
          if (log_done) begin
            lnum_r  <= log_result;
            state_r <= S_LOGD;
          end
        end
        S_LOGD: state_r <= S_WAITD;
        S_WAITD: begin
          if (log_done) begin
            diff_r  <= (lnum_r > log_result) ? lnum_r - log_result : '0;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod_r  <= diff_r * yuvpsnr_pkg::TEN_LOG10_2_Q16;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          psnr_r  <= (rnd_sh > SH_W'(yuvpsnr_pkg::PSNR_MAX)) ? yuvpsnr_pkg::PSNR_MAX
                                                             : rnd_sh[PSNR_W-1:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_plane_r <= plane_r;
            out_psnr_r  <= psnr_r;
            out_exact_r <= zero_r;
            out_last_r  <= (plane_r == yuvpsnr_pkg::PLANE_V);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/yuv420_psnr_meter.sv
// ----------------------------------------------------------------------------
// yuv420_psnr_meter
// Per-plane PSNR of an 8-bit YUV 4:2:0 test frame against a reference frame.
// ----------------------------------------------------------------------------
// Takes one reference/test sample pair per cycle, Y plane then U then V in
// raster order, and emits one result per plane: PSNR in unsigned Q8.8 dB,
// 0xFFFF with exact_match set when the plane has no error. Each plane total
// goes into a queue of QUEUE_DEPTH entries; one shared logarithm unit then
// takes two logarithms per plane with error, each a normalisation followed by
// sixteen squarings; a plane with no error needs no logarithm. Input stalls
// only when the queue is full, which happens when planes arrive faster than
// the back end finishes them or when the result side holds back.
// ----------------------------------------------------------------------------
module yuv420_psnr_meter #(
  parameter int MAX_DIM     = yuvpsnr_pkg::DEF_MAX_DIM,
  parameter int QUEUE_DEPTH = yuvpsnr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [yuvpsnr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yuvpsnr_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*yuvpsnr_pkg::SAMPLE_W-1:0]  in_tdata,   // sample_ref, sample_test
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [yuvpsnr_pkg::PSNR_W-1:0]      out_tdata,  // psnr_db_q8
  output logic [yuvpsnr_pkg::PLANE_W:0]       out_tuser,  // plane, exact_match
  output logic                                out_tlast
);

  localparam int CNT_W   = yuvpsnr_pkg::cnt_width(MAX_DIM);
  localparam int SSE_W   = yuvpsnr_pkg::sse_width(MAX_DIM);
  localparam int ENTRY_W = yuvpsnr_pkg::PLANE_W + CNT_W + SSE_W;
  localparam int RES_W   = yuvpsnr_pkg::log_res_width(SSE_W);

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic               log_start, log_done;
  logic [SSE_W-1:0]   log_x;
  logic [RES_W-1:0]   log_result;

  yuvpsnr_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  yuvpsnr_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  yuvpsnr_log2 #(.IN_W(SSE_W)) u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_result)
  );

  yuvpsnr_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .log_start  (log_start),
    .log_x      (log_x),
    .log_done   (log_done),
    .log_result (log_result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
